>>> rtl/utf8_stream_decoder_top_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define U8SD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define U8SD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/u8sd_pkg.sv
package u8sd_pkg;

    localparam int U8SD_QUEUE_DEPTH = 4;

    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int BYTE_W = 8;

    localparam logic [CP_W-1:0]   U8SD_REPLACEMENT = 21'h00FFFD;
    localparam logic [BYTE_W-1:0] U8SD_ASCII_END   = 8'h80;
    localparam logic [BYTE_W-1:0] U8SD_LEAD_MIN    = 8'hC2;
    localparam logic [BYTE_W-1:0] U8SD_LEAD_E0     = 8'hE0;
    localparam logic [BYTE_W-1:0] U8SD_LEAD_F0     = 8'hF0;
    localparam logic [BYTE_W-1:0] U8SD_LEAD_F4     = 8'hF4;
    localparam logic [BYTE_W-1:0] U8SD_E0_MIN      = 8'hA0;
    localparam logic [BYTE_W-1:0] U8SD_F0_MIN      = 8'h90;
    localparam logic [BYTE_W-1:0] U8SD_F4_MAX      = 8'h8F;

    // A job is the set of results one input item causes: err_cnt error
    // replacements, then an optional decoded character.
    typedef struct packed {
        logic [LEN_W-1:0] err_cnt;
        logic             has_char;
        logic [CP_W-1:0]  char_cp;
        logic [LEN_W-1:0] char_used;
    } job_t;

endpackage

>>> rtl/u8sd_front.sv
`include "utf8_stream_decoder_top_macros.svh"

module u8sd_front
    import u8sd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_end,
    output logic              push,
    output job_t              job
);

    logic [BYTE_W-1:0] lead_reg, lead_next;
    logic [CP_W-1:0]   partial_reg, partial_next;
    logic [LEN_W-1:0]  exp_reg, exp_next;
    logic [LEN_W-1:0]  held_reg, held_next;

    logic idle;
    logic cont;
    logic first_bad;
    logic follow_ok;

    always_comb
    begin
        idle      = (exp_reg == '0);
        cont      = (in_byte[7:6] == 2'b10);
        first_bad = (held_reg == LEN_W'(1)) &&
                    (((lead_reg == U8SD_LEAD_E0) && (in_byte < U8SD_E0_MIN)) ||
                     ((lead_reg == U8SD_LEAD_F0) && (in_byte < U8SD_F0_MIN)) ||
                     ((lead_reg == U8SD_LEAD_F4) && (in_byte > U8SD_F4_MAX)));
        follow_ok = !idle && cont && !first_bad;

        job.err_cnt   = '0;
        job.has_char  = 1'b0;
        job.char_cp   = '0;
        job.char_used = LEN_W'(1);

        lead_next    = lead_reg;
        partial_next = partial_reg;
        exp_next     = exp_reg;
        held_next    = held_reg;

        if (follow_ok)
        begin
            partial_next = {partial_reg[CP_W-7:0], in_byte[5:0]};
            held_next    = held_reg + LEN_W'(1);
            if (held_next >= exp_reg)
            begin
                job.has_char  = 1'b1;
                job.char_cp   = partial_next;
                job.char_used = exp_reg;
                lead_next     = '0;
                partial_next  = '0;
                exp_next      = '0;
                held_next     = '0;
            end
        end
        else
        begin
            job.err_cnt  = idle ? '0 : held_reg;
            lead_next    = '0;
            partial_next = '0;
            exp_next     = '0;
            held_next    = '0;
            if (in_byte < U8SD_ASCII_END)
            begin
                job.has_char = 1'b1;
                job.char_cp  = CP_W'(in_byte);
            end
            else if ((in_byte < U8SD_LEAD_MIN) || (in_byte > U8SD_LEAD_F4))
            begin
                job.err_cnt = job.err_cnt + LEN_W'(1);
            end
            else
            begin
                lead_next = in_byte;
                held_next = LEN_W'(1);
                if (in_byte < U8SD_LEAD_E0)
                begin
                    exp_next     = LEN_W'(2);
                    partial_next = CP_W'(in_byte[4:0]);
                end
                else if (in_byte < U8SD_LEAD_F0)
                begin
                    exp_next     = LEN_W'(3);
                    partial_next = CP_W'(in_byte[3:0]);
                end
                else
                begin
                    exp_next     = LEN_W'(4);
                    partial_next = CP_W'(in_byte[2:0]);
                end
            end
        end

        if (in_end && (exp_next != '0))
        begin
            job.err_cnt  = job.err_cnt + held_next;
            lead_next    = '0;
            partial_next = '0;
            exp_next     = '0;
            held_next    = '0;
        end

        push = accept && ((job.err_cnt != '0) || job.has_char);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg    <= '0;
            partial_reg <= '0;
            exp_reg     <= '0;
            held_reg    <= '0;
        end
        else if (accept)
        begin
            lead_reg    <= lead_next;
            partial_reg <= partial_next;
            exp_reg     <= exp_next;
            held_reg    <= held_next;
        end
    end

    `U8SD_ASSERT_IMPLY(a_held_below_len, clk, rst_n, exp_reg != '0, held_reg < exp_reg)
    `U8SD_ASSERT_IMPLY(a_idle_clear, clk, rst_n, exp_reg == '0, held_reg == '0)

endmodule

>>> rtl/u8sd_queue.sv
`include "utf8_stream_decoder_top_macros.svh"

module u8sd_queue
    import u8sd_pkg::*;
#(
    parameter int DEPTH = U8SD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic ready,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    job_t               store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    always_comb
    begin
        ready       = (count_reg < CNT_W'(DEPTH));
        head_valid  = (count_reg != '0);
        head_job    = store_reg[rd_ptr_reg];
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next  = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `U8SD_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, count_reg < CNT_W'(DEPTH))

endmodule

>>> rtl/u8sd_back.sv
`include "utf8_stream_decoder_top_macros.svh"

module u8sd_back
    import u8sd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  job_t             head_job,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CP_W-1:0]  out_cp,
    output logic             out_bad,
    output logic [LEN_W-1:0] out_used,
    output logic             out_last
);

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic             bad_reg, bad_next;
    logic [LEN_W-1:0] used_reg, used_next;
    logic             last_reg, last_next;
    logic [LEN_W-1:0] item_count;
    logic             emit;
    logic             is_err;
    logic             is_last;

    always_comb
    begin
        item_count = head_job.err_cnt + LEN_W'(head_job.has_char);
        emit       = head_valid && (!valid_reg || out_ready);
        is_err     = (idx_reg < head_job.err_cnt);
        is_last    = (idx_reg == (item_count - LEN_W'(1)));
        pop        = emit && is_last;

        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        cp_next    = cp_reg;
        bad_next   = bad_reg;
        used_next  = used_reg;
        last_next  = last_reg;

        if (emit)
        begin
            valid_next = 1'b1;
            cp_next    = is_err ? U8SD_REPLACEMENT : head_job.char_cp;
            bad_next   = is_err;
            used_next  = is_err ? LEN_W'(1) : head_job.char_used;
            last_next  = is_last;
            idx_next   = is_last ? '0 : idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        bad_reg  <= bad_next;
        used_reg <= used_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_cp    = cp_reg;
    assign out_bad   = bad_reg;
    assign out_used  = used_reg;
    assign out_last  = last_reg;

    `U8SD_ASSERT_IMPLY(a_idx_in_job, clk, rst_n, head_valid, idx_reg < item_count)
    `U8SD_ASSERT_IMPLY(a_idx_idle, clk, rst_n, !head_valid, idx_reg == '0)

endmodule

>>> rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder. One byte is accepted per cycle on the s_axis side
// and one decoded result leaves per cycle on the m_axis side while the
// receiver is ready. A byte that causes k results (k is 0 to 4, more than
// one only around malformed input) holds the output side until all k have
// left; a queue of QUEUE_DEPTH jobs between byte classifier and result
// generator absorbs these bursts, so input stalls only when the queue is
// full, that is when result bursts or a stalled receiver outpace the drain.
// A byte's first result goes through the queue, then the output register.

module utf8_stream_decoder_top
    import u8sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = U8SD_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // code_point [20:0], bytes_used [23:21]
    output logic        m_axis_tuser,   // malformed
    output logic        m_axis_tlast
);

    logic             accept;
    logic             push;
    job_t             push_job;
    logic             q_ready;
    logic             pop;
    logic             head_valid;
    job_t             head_job;
    logic [CP_W-1:0]  out_cp;
    logic [LEN_W-1:0] out_used;

    assign s_axis_tready = q_ready;
    assign accept        = s_axis_tvalid && q_ready;

    u8sd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .in_end  (s_axis_tlast),
        .push    (push),
        .job     (push_job)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u8sd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_cp     (out_cp),
        .out_bad    (m_axis_tuser),
        .out_used   (out_used),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_used, out_cp};

endmodule

>>> bench/tb_utf8_stream_decoder_top.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_top
    import u8sd_pkg::*;
;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             malformed;
        logic [LEN_W-1:0] bytes_used;
        logic             last_of_run;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tlast;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // code_point [20:0], bytes_used [23:21]
    logic        m_axis_tuser;   // malformed
    logic        m_axis_tlast;   // last_of_run

    utf8_stream_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Decoder state mirrored by the predictor.
    logic [7:0]       pend_lead;
    logic [CP_W-1:0]  pend_code;
    logic [LEN_W-1:0] pend_len;
    logic [LEN_W-1:0] pend_held;

    decoded_t step_buf [4];
    int       step_count;
    decoded_t expected_chars [$];

    int  mismatch_count = 0;
    int  bytes_sent = 0;
    int  results_checked = 0;
    int  replacements_seen = 0;
    bit  steady_flow = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_cycles = 0;
    int  hold_left = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void add_result(input logic [CP_W-1:0] cp, input logic bad,
                                       input logic [LEN_W-1:0] used);
        if (step_count < 4)
        begin
            step_buf[step_count] = '{code_point: cp, malformed: bad, bytes_used: used,
                                     last_of_run: 1'b0};
            step_count++;
        end
    endfunction

    function automatic void flush_pending();
        for (int i = 0; i < pend_held && i < 4; i++)
            add_result(U8SD_REPLACEMENT, 1'b1, 3'd1);
        pend_lead = '0;
        pend_code = '0;
        pend_len  = '0;
        pend_held = '0;
    endfunction

    function automatic void start_sequence(input logic [7:0] b);
        if (b < U8SD_ASCII_END)
            add_result({13'd0, b}, 1'b0, 3'd1);
        else if (b < U8SD_LEAD_MIN || b > U8SD_LEAD_F4)
            add_result(U8SD_REPLACEMENT, 1'b1, 3'd1);
        else
        begin
            pend_lead = b;
            pend_held = 3'd1;
            if (b < U8SD_LEAD_E0)
            begin
                pend_len  = 3'd2;
                pend_code = {16'd0, b[4:0]};
            end
            else if (b < U8SD_LEAD_F0)
            begin
                pend_len  = 3'd3;
                pend_code = {17'd0, b[3:0]};
            end
            else
            begin
                pend_len  = 3'd4;
                pend_code = {18'd0, b[2:0]};
            end
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic eot);
        logic fits;
        step_count = 0;
        if (pend_len == 0)
            start_sequence(b);
        else
        begin
            fits = (b[7:6] == 2'b10);
            if (fits && pend_held == 1)
            begin
                if (pend_lead == U8SD_LEAD_E0 && b < U8SD_E0_MIN)
                    fits = 1'b0;
                if (pend_lead == U8SD_LEAD_F0 && b < U8SD_F0_MIN)
                    fits = 1'b0;
                if (pend_lead == U8SD_LEAD_F4 && b > U8SD_F4_MAX)
                    fits = 1'b0;
            end
            if (fits)
            begin
                pend_code = {pend_code[CP_W-7:0], b[5:0]};
                pend_held = pend_held + 3'd1;
                if (pend_held >= pend_len)
                begin
                    add_result(pend_code, 1'b0, pend_len);
                    pend_held = pend_len;
                    pend_held = '0;
                    pend_lead = '0;
                    pend_code = '0;
                    pend_len  = '0;
                end
            end
            else
            begin
                flush_pending();
                start_sequence(b);
            end
        end
        if (eot && pend_len != 0)
            flush_pending();
        if (step_count > 0)
            step_buf[step_count-1].last_of_run = 1'b1;
        for (int i = 0; i < step_count; i++)
            expected_chars.push_back(step_buf[i]);
    endfunction

    // Entered and left at a falling edge; valid stays high for a following item.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (!steady_flow)
        begin
            while ($urandom_range(99) < 35)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_byte(b, eot);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic sender_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        while (expected_chars.size() != 0)
            @(negedge clk);
    endtask

    function automatic int unsigned utf8_encode(input logic [20:0] cp,
                                                output logic [7:0] seq [4]);
        seq[0] = 8'h00;
        seq[1] = 8'h80;
        seq[2] = 8'h80;
        seq[3] = 8'h80;
        if (cp < 21'h80)
        begin
            seq[0] = cp[7:0];
            return 1;
        end
        else if (cp < 21'h800)
        begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            return 2;
        end
        else if (cp < 21'h10000)
        begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            return 3;
        end
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    function automatic logic [20:0] random_code_point(input int unsigned len);
        case (len)
            1: return 21'($urandom_range(32'h7F, 0));
            2: return 21'($urandom_range(32'h7FF, 32'h80));
            3: return 21'($urandom_range(32'hFFFF, 32'h800));
            default: return 21'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
    endfunction

    // Sends the first n bytes of the encoding; the end mark falls at random.
    task automatic send_sequence(input logic [20:0] cp, input int unsigned n);
        logic [7:0]  seq [4];
        int unsigned len;
        len = utf8_encode(cp, seq);
        for (int i = 0; i < len && i < n; i++)
            send_byte(seq[i], $urandom_range(99) < 4);
    endtask

    task automatic test_valid_sequences();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_sequence(21'h80, 4);
        send_sequence(21'hFFFD, 4);
        send_sequence(21'hD800, 4);
        send_sequence(21'h10FFFF, 4);
    endtask

    task automatic test_invalid_leads();
        send_byte(8'hC1, 1'b0);
        send_byte(8'hF5, 1'b0);
    endtask

    task automatic test_broken_sequences();
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_end_of_text();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // The receiver stalls while error bursts keep arriving, so the job queue
    // fills and the decoder has to stop taking bytes.
    task automatic test_output_backpressure();
        hold_cycles = 80;
        hold_requests++;
        for (int i = 0; i < 12; i++)
            send_byte(8'($urandom_range(255, 245)), 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            send_byte(8'hE2, 1'b0);
            send_byte(8'h82, 1'b0);
            send_byte(8'($urandom_range(126, 32)), 1'b0);
        end
        sender_idle();
        wait_results_drained();
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 6; i++)
            send_sequence(random_code_point($urandom_range(4, 1)), 4);
        sender_idle();
        wait_results_drained();
        for (int i = 0; i < 6; i++)
            send_sequence(random_code_point($urandom_range(4, 1)), 4);
    endtask

    task automatic test_random_text();
        int start_count;
        int unsigned pick;
        int unsigned len;
        start_count = bytes_sent;
        while (bytes_sent - start_count < 150)
        begin
            steady_flow = (bytes_sent - start_count >= 50) && (bytes_sent - start_count < 110);
            pick = $urandom_range(99);
            len  = $urandom_range(4, 1);
            if (pick < 70)
                send_sequence(random_code_point(len), 4);
            else if (pick < 80)
                send_sequence(random_code_point($urandom_range(4, 2)),
                              $urandom_range(len > 1 ? len - 1 : 1, 1));
            else if (pick < 90)
                send_byte(8'($urandom_range(255, 0)), $urandom_range(99) < 10);
            else
                send_byte(8'($urandom_range(8'hBF, 8'h80)), 1'b0);
        end
        steady_flow = 0;
    endtask

    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_left   = hold_cycles;
            hold_served = hold_requests;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (steady_flow)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_chars.size() == 0)
                report_mismatch("unexpected result", {8'd0, m_axis_tdata}, 32'd0);
            else
            begin
                want = expected_chars.pop_front();
                if (m_axis_tdata[20:0] != want.code_point)
                    report_mismatch("code_point", 32'(m_axis_tdata[20:0]),
                                    32'(want.code_point));
                if (m_axis_tuser != want.malformed)
                    report_mismatch("malformed", 32'(m_axis_tuser), 32'(want.malformed));
                if (m_axis_tdata[23:21] != want.bytes_used)
                    report_mismatch("bytes_used", 32'(m_axis_tdata[23:21]),
                                    32'(want.bytes_used));
                if (m_axis_tlast != want.last_of_run)
                    report_mismatch("last_of_run", 32'(m_axis_tlast),
                                    32'(want.last_of_run));
                if (want.malformed)
                    replacements_seen++;
                results_checked++;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        pend_lead     = '0;
        pend_code     = '0;
        pend_len      = '0;
        pend_held     = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_valid_sequences();
        test_invalid_leads();
        test_broken_sequences();
        test_end_of_text();
        test_output_backpressure();
        test_sender_pause();
        test_random_text();

        sender_idle();
        wait_results_drained();
        repeat (10) @(negedge clk);
        if (expected_chars.size() != 0)
            report_mismatch("results never delivered", 32'(expected_chars.size()), 32'd0);

        $display("Sent %0d bytes and checked %0d code points, %0d of them replacements.",
                 bytes_sent, results_checked, replacements_seen);
        $display("Covered valid, invalid, broken and truncated sequences under stalls.");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
